// ----- hdl/tdcp_pkg.sv -----
// Package for the time and date command parser.
// Holds frame layout constants, character codes, status codes and the
// record type passed from the front end to the back end. No dependencies.
`default_nettype none

package tdcp_pkg;

  localparam int FRAME_BUFFER_SIZE = 32;
  localparam int POS_W             = $clog2(FRAME_BUFFER_SIZE);
  localparam int LAST_POS          = FRAME_BUFFER_SIZE - 1;
  localparam int CLOSE_POS         = 18;

  localparam int NUM_FIELDS = 6;
  localparam int NUM_DIGITS = 2 * NUM_FIELDS;
  localparam int NUM_SEPS   = 5;
  localparam int VAL_W      = 7;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int DIGIT_POS [NUM_DIGITS] = '{1, 2, 4, 5, 7, 8, 10, 11, 13, 14, 16, 17};
  localparam int SEP_POS [NUM_SEPS] = '{3, 6, 9, 12, 15};
  localparam logic [7:0] SEP_CHAR [NUM_SEPS] = '{CH_COLON, CH_COLON, CH_SPACE,
                                                 CH_SLASH, CH_SLASH};

  localparam logic [VAL_W-1:0] HOUR_LIMIT   = 7'd24;
  localparam logic [VAL_W-1:0] MINUTE_LIMIT = 7'd60;
  localparam logic [VAL_W-1:0] SECOND_LIMIT = 7'd60;
  localparam logic [VAL_W-1:0] DAY_MAX      = 7'd31;
  localparam logic [VAL_W-1:0] MONTH_MAX    = 7'd12;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef struct packed {
    logic                       fmt_ok;
    logic                       digits_ok;
    logic [NUM_DIGITS-1:0][3:0] nibbles;
  } frame_rec_t;

endpackage

`default_nettype wire

// ----- hdl/tdcp_front.sv -----
// Front end of the time and date command parser: tracks the frame position
// and captures digit and separator bytes; emits one record per closed frame.
// Depends on tdcp_pkg.
`default_nettype none

module tdcp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  output tdcp_pkg::frame_rec_t   rec_o,
  output logic                   push_o
);

  logic [tdcp_pkg::POS_W-1:0]    pos_q, pos_d, at;
  logic                          open_q, open_d;
  logic [tdcp_pkg::NUM_DIGITS-1:0][3:0] nib_q;
  logic [tdcp_pkg::NUM_DIGITS-1:0]      dig_q;
  logic [tdcp_pkg::NUM_SEPS-1:0]        sep_q;
  logic                          is_open, is_close, is_digit;

  assign is_open  = (byte_i == tdcp_pkg::CH_OPEN);
  assign is_close = (byte_i == tdcp_pkg::CH_CLOSE);
  assign is_digit = (byte_i >= tdcp_pkg::CH_ZERO) && (byte_i <= tdcp_pkg::CH_NINE);
  assign at       = is_open ? '0 : pos_q;

  always_comb begin
    pos_d  = pos_q;
    open_d = open_q;
    if (fire_i) begin
      if (at < tdcp_pkg::POS_W'(tdcp_pkg::LAST_POS)) begin
        pos_d = at + 1'b1;
      end else begin
        pos_d = at;
      end
      if (is_open) begin
        open_d = 1'b1;
      end else if (is_close) begin
        open_d = 1'b0;
      end
    end
  end

  assign push_o          = fire_i && is_close && open_q;
  assign rec_o.fmt_ok    = (at == tdcp_pkg::POS_W'(tdcp_pkg::CLOSE_POS)) && (&sep_q);
  assign rec_o.digits_ok = &dig_q;
  assign rec_o.nibbles   = nib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      open_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < tdcp_pkg::NUM_DIGITS; k++) begin
      if (fire_i && (at == tdcp_pkg::POS_W'(tdcp_pkg::DIGIT_POS[k]))) begin
        nib_q[k] <= byte_i[3:0];
        dig_q[k] <= is_digit;
      end
    end
    for (int s = 0; s < tdcp_pkg::NUM_SEPS; s++) begin
      if (fire_i && (at == tdcp_pkg::POS_W'(tdcp_pkg::SEP_POS[s]))) begin
        sep_q[s] <= (byte_i == tdcp_pkg::SEP_CHAR[s]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tdcp_queue.sv -----
// Two-entry queue of frame records between the front and back ends.
// Depends on tdcp_pkg.
`default_nettype none

module tdcp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tdcp_pkg::frame_rec_t rec_i,
  input  wire logic              pop_i,
  output tdcp_pkg::frame_rec_t   head_o,
  output logic                   valid_o,
  output logic                   full_o
);

  tdcp_pkg::frame_rec_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tdcp_back.sv -----
// Back end of the time and date command parser: decodes a frame record,
// checks ranges, tracks first synchronization and holds the result word.
// Depends on tdcp_pkg.
`default_nettype none

module tdcp_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           head_valid_i,
  input  wire tdcp_pkg::frame_rec_t           head_i,
  output logic                                pop_o,
  input  wire logic                           res_ready_i,
  output logic                                res_valid_o,
  output logic [1:0]                          status_o,
  output logic [tdcp_pkg::NUM_FIELDS-1:0][tdcp_pkg::VAL_W-1:0] values_o,
  output logic                                first_sync_o
);

  logic [tdcp_pkg::NUM_FIELDS-1:0][tdcp_pkg::VAL_W-1:0] val;
  logic                 range_ok;
  tdcp_pkg::status_e    status_d;
  logic                 valid_q, synced_q;
  logic [1:0]           status_q;
  logic [tdcp_pkg::NUM_FIELDS-1:0][tdcp_pkg::VAL_W-1:0] values_q;
  logic                 first_q;

  always_comb begin
    for (int f = 0; f < tdcp_pkg::NUM_FIELDS; f++) begin
      val[f] = tdcp_pkg::VAL_W'({4'b0, head_i.nibbles[2*f], 3'b0}
                               + {5'b0, head_i.nibbles[2*f], 1'b0}
                               + {4'b0, head_i.nibbles[2*f+1]});
    end
  end

  assign range_ok = head_i.digits_ok
                 && (val[0] < tdcp_pkg::HOUR_LIMIT)
                 && (val[1] < tdcp_pkg::MINUTE_LIMIT)
                 && (val[2] < tdcp_pkg::SECOND_LIMIT)
                 && (val[3] != '0) && (val[3] <= tdcp_pkg::DAY_MAX)
                 && (val[4] != '0) && (val[4] <= tdcp_pkg::MONTH_MAX);

  always_comb begin
    if (!head_i.fmt_ok) begin
      status_d = tdcp_pkg::ST_FORMAT;
    end else if (!range_ok) begin
      status_d = tdcp_pkg::ST_RANGE;
    end else begin
      status_d = tdcp_pkg::ST_OK;
    end
  end

  assign pop_o = head_valid_i && (!valid_q || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      synced_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        if (status_d == tdcp_pkg::ST_OK) begin
          synced_q <= 1'b1;
        end
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      values_q <= (status_d == tdcp_pkg::ST_OK) ? val : '0;
      first_q  <= (status_d == tdcp_pkg::ST_OK) && !synced_q;
    end
  end

  assign res_valid_o  = valid_q;
  assign status_o     = status_q;
  assign values_o     = values_q;
  assign first_sync_o = first_q;

  a_values_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o != tdcp_pkg::ST_OK) |-> (values_o == '0))
    else $error("decoded values not cleared on a failed frame");

  a_first_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && first_sync_o |-> (status_o == tdcp_pkg::ST_OK))
    else $error("first sync flagged on a failed frame");

  a_first_only_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && synced_q |=> !first_sync_o)
    else $error("first sync flagged after synchronization");

  a_synced_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    synced_q |=> synced_q)
    else $error("synchronization flag dropped");

endmodule

`default_nettype wire

// ----- hdl/time_date_command_parser.sv -----
// Time and date command parser, top level: front end, record queue, back end.
// Depends on tdcp_pkg, tdcp_front, tdcp_queue and tdcp_back.
//
// Takes one received byte per cycle while rx_ready_o is high, frames commands
// [HH:MM:SS DD/MM/YY]; a ']' closing an open frame yields one result word
// via the record queue and result register; other bytes yield none. The front
// end captures each accepted byte; a two-entry record queue decouples it from
// the result register, so rx_ready_o drops only when both entries are unread.
`default_nettype none

module time_date_command_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [1:0]      status_o,
  output logic [6:0]      hour_value_o,
  output logic [6:0]      minute_value_o,
  output logic [6:0]      second_value_o,
  output logic [6:0]      day_value_o,
  output logic [6:0]      month_value_o,
  output logic [6:0]      year_value_o,
  output logic            first_sync_o
);

  tdcp_pkg::frame_rec_t rec, head;
  logic                 push, pop, head_valid, full, fire;
  logic [tdcp_pkg::NUM_FIELDS-1:0][tdcp_pkg::VAL_W-1:0] values;

  assign rx_ready_o = !full;
  assign fire       = rx_valid_i && rx_ready_o;

  tdcp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (rx_byte_i),
    .rec_o  (rec),
    .push_o (push)
  );

  tdcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  tdcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_ready_i  (res_ready_i),
    .res_valid_o  (res_valid_o),
    .status_o     (status_o),
    .values_o     (values),
    .first_sync_o (first_sync_o)
  );

  assign hour_value_o   = values[0];
  assign minute_value_o = values[1];
  assign second_value_o = values[2];
  assign day_value_o    = values[3];
  assign month_value_o  = values[4];
  assign year_value_o   = values[5];

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for time_date_command_parser: sends framed and broken command bytes and
// predicts each reply in a scoreboard class, then checks replies field by field.
// Depends on tdcp_pkg and the time_date_command_parser RTL.
`timescale 1ns / 100ps

module tb;
  import tdcp_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    status_e    status;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] sec;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic       first_sync;
  } time_reply_t;

  class command_tracker;
    logic [7:0]       frame_mem [FRAME_BUFFER_SIZE];
    logic [POS_W-1:0] write_pos;
    bit               frame_live;
    bit               synced;
    time_reply_t      expected_replies [$];
    int               errors;
    int               ok_seen;
    int               format_seen;
    int               range_seen;

    function new();
      write_pos   = '0;
      frame_live  = 1'b0;
      synced      = 1'b0;
      errors      = 0;
      ok_seen     = 0;
      format_seen = 0;
      range_seen  = 0;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    endfunction

    function time_reply_t decode_command(int close_at);
      time_reply_t r;
      int          v [6];
      int          i;
      logic [7:0]  hi;
      logic [7:0]  lo;
      bit          fmt_bad;
      bit          digits_ok;
      r = '0;
      fmt_bad = (close_at != CLOSE_POS);
      for (i = 0; i < NUM_SEPS; i++) begin
        if (frame_mem[SEP_POS[i]] != SEP_CHAR[i]) fmt_bad = 1'b1;
      end
      if (fmt_bad) begin
        r.status = ST_FORMAT;
        return r;
      end
      digits_ok = 1'b1;
      for (i = 0; i < NUM_FIELDS; i++) begin
        hi = frame_mem[1 + 3 * i];
        lo = frame_mem[2 + 3 * i];
        v[i] = 0;
        if (hi < CH_ZERO || hi > CH_NINE || lo < CH_ZERO || lo > CH_NINE) begin
          digits_ok = 1'b0;
        end else begin
          v[i] = int'(hi - CH_ZERO) * 10 + int'(lo - CH_ZERO);
        end
      end
      if (!digits_ok || v[0] >= HOUR_LIMIT || v[1] >= MINUTE_LIMIT ||
          v[2] >= SECOND_LIMIT || v[3] < 1 || v[3] > DAY_MAX ||
          v[4] < 1 || v[4] > MONTH_MAX) begin
        r.status = ST_RANGE;
        return r;
      end
      r.status     = ST_OK;
      r.hour       = 7'(v[0]);
      r.minute     = 7'(v[1]);
      r.sec        = 7'(v[2]);
      r.day        = 7'(v[3]);
      r.month      = 7'(v[4]);
      r.year       = 7'(v[5]);
      r.first_sync = !synced;
      synced       = 1'b1;
      return r;
    endfunction

    function void take_byte(logic [7:0] b);
      int at;
      if (b == CH_OPEN) begin
        write_pos  = '0;
        frame_live = 1'b1;
      end
      at = write_pos;
      frame_mem[at] = b;
      if (write_pos < LAST_POS) write_pos++;
      if (b == CH_CLOSE && frame_live) begin
        expected_replies.push_back(decode_command(at));
        frame_live = 1'b0;
      end
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $error("%s expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(time_reply_t got);
      time_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with status %0d arrived with no command pending", got.status);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      case (want.status)
        ST_OK:     ok_seen++;
        ST_FORMAT: format_seen++;
        default:   range_seen++;
      endcase
      cmp_field("status", want.status, got.status);
      cmp_field("hour_value", want.hour, got.hour);
      cmp_field("minute_value", want.minute, got.minute);
      cmp_field("second_value", want.sec, got.sec);
      cmp_field("day_value", want.day, got.day);
      cmp_field("month_value", want.month, got.month);
      cmp_field("year_value", want.year, got.year);
      cmp_field("first_sync", want.first_sync, got.first_sync);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       res_ready_i = 1'b0;
  logic       rx_ready_o;
  logic       res_valid_o;
  logic [1:0] status_o;
  logic [6:0] hour_value_o;
  logic [6:0] minute_value_o;
  logic [6:0] second_value_o;
  logic [6:0] day_value_o;
  logic [6:0] month_value_o;
  logic [6:0] year_value_o;
  logic       first_sync_o;

  command_tracker sb;
  logic [7:0]     cmd_q [$];
  int             words_sent    = 0;
  int             send_idle_pct = 27;
  int             recv_idle_pct = 54;

  time_date_command_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .status_o       (status_o),
    .hour_value_o   (hour_value_o),
    .minute_value_o (minute_value_o),
    .second_value_o (second_value_o),
    .day_value_o    (day_value_o),
    .month_value_o  (month_value_o),
    .year_value_o   (year_value_o),
    .first_sync_o   (first_sync_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : reply_monitor
    time_reply_t seen;
    if (rst_ni && res_valid_o && res_ready_i) begin
      seen.status     = status_e'(status_o);
      seen.hour       = hour_value_o;
      seen.minute     = minute_value_o;
      seen.sec        = second_value_o;
      seen.day        = day_value_o;
      seen.month      = month_value_o;
      seen.year       = year_value_o;
      seen.first_sync = first_sync_o;
      sb.match_reply(seen);
    end
    res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.take_byte(b);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic wait_replies_drained();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick(int lo, int hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic void build_command();
    int         kind;
    int         base;
    int         at;
    int         idx;
    int         n;
    int         i;
    int         v [6];
    logic [7:0] b;
    cmd_q.delete();
    kind = $urandom_range(99);
    if (kind >= 94) begin
      n = $urandom_range(1, 8);
      repeat (n) cmd_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) cmd_q.push_back(CH_CLOSE);
      return;
    end
    v[0] = pick(0, 23);
    v[1] = pick(0, 59);
    v[2] = pick(0, 59);
    v[3] = pick(1, 31);
    v[4] = pick(1, 12);
    v[5] = pick(0, 99);
    if (kind >= 45 && kind < 60) begin
      case ($urandom_range(4))
        0:       v[0] = $urandom_range(24, 99);
        1:       v[1] = $urandom_range(60, 99);
        2:       v[2] = $urandom_range(60, 99);
        3:       v[3] = $urandom_range(1) ? 0 : $urandom_range(32, 99);
        default: v[4] = $urandom_range(1) ? 0 : $urandom_range(13, 99);
      endcase
    end
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) cmd_q.push_back(8'($urandom_range(255)));
    end
    base = cmd_q.size();
    cmd_q.push_back(CH_OPEN);
    for (i = 0; i < NUM_FIELDS; i++) begin
      cmd_q.push_back(8'(CH_ZERO + v[i] / 10));
      cmd_q.push_back(8'(CH_ZERO + v[i] % 10));
      if (i < NUM_SEPS) cmd_q.push_back(SEP_CHAR[i]);
    end
    if (kind >= 60 && kind < 70) begin
      at = base + DIGIT_POS[$urandom_range(NUM_DIGITS - 1)];
      do b = 8'($urandom_range(255)); while (b >= CH_ZERO && b <= CH_NINE);
      cmd_q[at] = b;
    end else if (kind >= 70 && kind < 80) begin
      idx = $urandom_range(NUM_SEPS - 1);
      do begin
        b = $urandom_range(1) ? SEP_CHAR[$urandom_range(NUM_SEPS - 1)]
                              : 8'($urandom_range(255));
      end while (b == SEP_CHAR[idx]);
      cmd_q[base + SEP_POS[idx]] = b;
    end else if (kind >= 80 && kind < 88) begin
      at = base + $urandom_range(1, 17);
      case ($urandom_range(2))
        0:       cmd_q.delete(at);
        1:       cmd_q.insert(at, 8'(CH_ZERO + $urandom_range(9)));
        default: while (cmd_q.size() > at) void'(cmd_q.pop_back());
      endcase
    end else if (kind >= 88) begin
      n = $urandom_range(14, 30);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == CH_OPEN || b == CH_CLOSE);
        cmd_q.push_back(b);
      end
    end
    cmd_q.push_back(CH_CLOSE);
  endfunction

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int goal;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("[23:59:59 31/12/99]");
    send_text("]");
    send_text("[]");
    send_word(8'h00);
    send_word(8'hFF);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = words_sent + ITEM_TARGET / 3;
      while (words_sent < goal) begin
        build_command();
        foreach (cmd_q[i]) send_word(cmd_q[i]);
      end
      wait_replies_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_replies.size() != 0) begin
      $error("%0d replies never arrived", sb.expected_replies.size());
      sb.errors++;
    end
    $display("Sent %0d bytes over three idle/stall mixes with a full drain between them;",
             words_sent);
    $display("replies checked: %0d valid commands, %0d format errors, %0d range errors.",
             sb.ok_seen, sb.format_seen, sb.range_seen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
